[hdl/b2da_pkg.sv]
// Package for the binary to decimal ASCII converter.
// Holds field widths, shared constants, the front-end state type and digit sizing.
// No dependencies.
package b2da_pkg;

  localparam int unsigned ValueW       = 64;
  localparam int unsigned CharW        = 6;
  localparam int unsigned PosW         = 5;
  localparam int unsigned DefValueBits = 64;
  localparam int unsigned BitsPerStep  = 4;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [CharW-1:0] AsciiZero  = 6'd48;
  localparam logic [3:0]       DabbleMin  = 4'd5;
  localparam logic [3:0]       DabbleAdd  = 4'd3;

  typedef enum logic [1:0] {
    FrIdle,
    FrConv,
    FrPush
  } fr_state_e;

  // Decimal digits needed for the largest value of the given bit width.
  function automatic int unsigned num_digits(int unsigned bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

endpackage

[hdl/b2da_if.sv]
// Handshake interfaces for the binary to decimal ASCII converter.
// One interface carries input values, the other carries digit beats.
// Depends on b2da_pkg.
interface b2da_in_if import b2da_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

interface b2da_out_if import b2da_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] digit_char;
  logic [PosW-1:0]  digit_position;
  logic             last_digit;

  modport source (output valid, digit_char, digit_position, last_digit, input ready);
  modport sink (input valid, digit_char, digit_position, last_digit, output ready);
endinterface

[hdl/b2da_front.sv]
// Front end: accepts a value and converts it to packed BCD by shift-and-add-3.
// Pushes the BCD word and its digit count into the queue.
// Depends on b2da_pkg and b2da_in_if.
module b2da_front import b2da_pkg::*; #(
  parameter int unsigned ValueBits = DefValueBits,
  localparam int unsigned NumDigits = num_digits(ValueBits),
  localparam int unsigned BcdW      = NumDigits * 4,
  localparam int unsigned EntryW    = BcdW + PosW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  b2da_in_if.sink           in_i,
  output logic              push_o,
  output logic [EntryW-1:0] entry_o,
  input  logic              full_i
);

  localparam int unsigned Steps = (ValueBits + BitsPerStep - 1) / BitsPerStep;
  localparam int unsigned PadW  = Steps * BitsPerStep;
  localparam int unsigned StepW = $clog2(Steps);

  fr_state_e        state_q, state_d;
  logic [BcdW-1:0]  bcd_q, bcd_d;
  logic [PadW-1:0]  sh_q, sh_d;
  logic [StepW-1:0] step_q, step_d;
  logic [BcdW-1:0]  bcd_nx;
  logic [PadW-1:0]  sh_nx;
  logic [PosW-1:0]  ndig;

  // Several dabble iterations per cycle: correct each digit, then shift one bit in.
  always_comb begin
    bcd_nx = bcd_q;
    sh_nx  = sh_q;
    for (int it = 0; it < BitsPerStep; it++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (bcd_nx[d*4 +: 4] >= DabbleMin) begin
          bcd_nx[d*4 +: 4] = bcd_nx[d*4 +: 4] + DabbleAdd;
        end
      end
      bcd_nx = {bcd_nx[BcdW-2:0], sh_nx[PadW-1]};
      sh_nx  = {sh_nx[PadW-2:0], 1'b0};
    end
  end

  // Digit count is the position of the highest nonzero digit, at least one.
  always_comb begin
    ndig = PosW'(1);
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd_q[d*4 +: 4] != 4'd0) begin
        ndig = PosW'(d + 1);
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    bcd_d      = bcd_q;
    sh_d       = sh_q;
    step_d     = step_q;
    push_o     = 1'b0;
    in_i.ready = 1'b0;
    case (state_q)
      FrIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          bcd_d   = '0;
          sh_d    = PadW'(in_i.value[ValueBits-1:0]);
          step_d  = StepW'(Steps - 1);
          state_d = FrConv;
        end
      end
      FrConv: begin
        bcd_d  = bcd_nx;
        sh_d   = sh_nx;
        step_d = step_q - StepW'(1);
        if (step_q == '0) begin
          state_d = FrPush;
        end
      end
      FrPush: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FrIdle;
        end
      end
      default: state_d = FrIdle;
    endcase
  end

  assign entry_o = {ndig, bcd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    sh_q   <= sh_d;
    step_q <= step_d;
  end

endmodule

[hdl/b2da_fifo.sv]
// Short queue between the front end and the digit sequencer.
// Holds converted BCD words with their digit counts.
// Depends on b2da_pkg.
module b2da_fifo import b2da_pkg::*; #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [Width-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth)) else $error("queue fill count out of range");

endmodule

[hdl/b2da_back.sv]
// Back end: takes a BCD word from the queue and sends its digits as ASCII beats.
// Most significant digit first, one beat per cycle through an output register while out_o is ready.
// Depends on b2da_pkg and b2da_out_if.
module b2da_back import b2da_pkg::*; #(
  parameter int unsigned ValueBits = DefValueBits,
  localparam int unsigned NumDigits = num_digits(ValueBits),
  localparam int unsigned BcdW      = NumDigits * 4,
  localparam int unsigned EntryW    = BcdW + PosW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  logic [EntryW-1:0] entry_i,
  output logic              pop_o,
  b2da_out_if.source        out_o
);

  localparam int unsigned IdxW = $clog2(NumDigits);

  logic                       busy_q, busy_d;
  logic [NumDigits-1:0][3:0]  bcd_q, bcd_d;
  logic [PosW-1:0]            ndig_q, ndig_d;
  logic [PosW-1:0]            pos_q, pos_d;
  logic                       out_valid_q, out_valid_d;
  logic [CharW-1:0]           char_q, char_d;
  logic [PosW-1:0]            opos_q, opos_d;
  logic                       last_q, last_d;
  logic                       load_out;
  logic                       emit;
  logic                       is_last;
  logic [PosW-1:0]            dig_sel;
  logic [IdxW-1:0]            idx;
  logic [3:0]                 digit;

  assign load_out = !out_valid_q || out_o.ready;
  assign emit     = busy_q && load_out;
  assign is_last  = (pos_q == ndig_q - PosW'(1));
  assign dig_sel  = ndig_q - PosW'(1) - pos_q;
  assign idx      = dig_sel[IdxW-1:0];
  assign digit    = bcd_q[idx];
  assign pop_o    = !empty_i && (!busy_q || (emit && is_last));

  always_comb begin
    busy_d      = busy_q;
    bcd_d       = bcd_q;
    ndig_d      = ndig_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    opos_d      = opos_q;
    last_d      = last_q;
    if (load_out) begin
      out_valid_d = emit;
      char_d      = AsciiZero + CharW'(digit);
      opos_d      = pos_q;
      last_d      = is_last;
    end
    if (emit) begin
      pos_d = pos_q + PosW'(1);
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      bcd_d  = entry_i[BcdW-1:0];
      ndig_d = entry_i[EntryW-1 -: PosW];
      pos_d  = '0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.digit_char     = char_q;
  assign out_o.digit_position = opos_q;
  assign out_o.last_digit     = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    ndig_q <= ndig_d;
    pos_q  <= pos_d;
    char_q <= char_d;
    opos_q <= opos_d;
    last_q <= last_d;
  end

  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !is_last) |=> (pos_q == $past(pos_q) + PosW'(1)))
    else $error("digit position did not advance");
  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.digit_position == '0) && !out_o.last_digit)
      |-> (out_o.digit_char != AsciiZero))
    else $error("leading zero digit sent");
  a_ndig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ((ndig_q != '0) && (ndig_q <= PosW'(NumDigits))))
    else $error("digit count out of range");

endmodule

[hdl/binary_to_decimal_ascii.sv]
// Top level of the binary to decimal ASCII converter.
// Ties the converting front end, the queue and the digit sequencer together.
// Depends on b2da_pkg, b2da_if, b2da_front, b2da_fifo and b2da_back.
//
// Usage: each beat on in_i carries one unsigned value; only its low ValueBits
// bits are converted. For each value the block sends one beat per decimal
// digit on out_o, most significant digit first, without leading zeros; zero
// gives the single digit '0'. A beat carries the ASCII code, the digit's
// position from the left and a flag set on the final digit.
// The front end takes the value, runs the shift-and-add-3 converter (four bits
// per cycle) and then hands the BCD word to the queue; the first digit passes
// through the queue, the sequencer's registers and the output register before
// it shows on out_o. The front end takes no new value until the previous one
// has gone to the queue, and the sequencer sends one digit per cycle while
// out_o is ready; a value has up to twenty digits.
// The two-entry queue lets the converter keep working while the sequencer is
// held up by a stalled receiver; digits stay in the output register until
// taken, and nothing is lost or repeated. Reset empties the queue, drops any
// value in conversion and clears out_o.valid; no other state is kept.
module binary_to_decimal_ascii import b2da_pkg::*; #(
  parameter int unsigned ValueBits = DefValueBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b2da_in_if.sink     in_i,
  b2da_out_if.source  out_o
);

  localparam int unsigned NumDigits = num_digits(ValueBits);
  localparam int unsigned EntryW    = NumDigits * 4 + PosW;

  logic              push;
  logic              full;
  logic              pop;
  logic              empty;
  logic [EntryW-1:0] wr_entry;
  logic [EntryW-1:0] rd_entry;

  // Front end: value in, packed BCD and digit count out.
  b2da_front #(
    .ValueBits(ValueBits)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .push_o  (push),
    .entry_o (wr_entry),
    .full_i  (full)
  );

  // Queue decouples conversion from digit output.
  b2da_fifo #(
    .Width(EntryW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (wr_entry),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (rd_entry),
    .empty_o (empty)
  );

  // Back end: one ASCII digit beat per cycle while out_o is ready.
  b2da_back #(
    .ValueBits(ValueBits)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .entry_i (rd_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for binary_to_decimal_ascii: values in, decimal digit beats out.
// Depends on b2da_pkg, the b2da_in_if and b2da_out_if interfaces and the block's RTL.
// A clocked driver and monitor run against an in-bench decimal predictor.
module tb_top;
  import b2da_pkg::*;

  // The block is built at its default width, and the predictor masks to the same width.
  localparam int unsigned ValueBits = DefValueBits;
  localparam int unsigned MaxDigits = 20;
  localparam int unsigned RandomItems = 410;

  // The run is cut off here. A correct run stays well below it: 431 values with up
  // to 20 digits each, random stalls on both sides and one long receiver hold-off.
  localparam int unsigned CycleLimit = 200000;

  // Neither side idles at random inside this window, so outside the hold-off the block also runs at full rate.
  localparam int unsigned QuietFrom = 1500;
  localparam int unsigned QuietTo = 3500;

  // The receiver is held off for this many cycles once enough values have gone in.
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned HoldOffAfter = 120;

  // The block may still be draining after the last expected digit arrives.
  localparam int unsigned DrainCycles = 40;

  localparam logic [ValueW-1:0] ValueMask =
      (ValueBits >= 64) ? {ValueW{1'b1}} : ((ValueW'(1) << ValueBits) - ValueW'(1));
  localparam logic [ValueW-1:0] MaxValue = {ValueW{1'b1}};
  localparam logic [ValueW-1:0] Radix = 64'd10;

  typedef struct packed {
    logic [CharW-1:0] ascii_code;
    logic [PosW-1:0]  position;
    logic             last;
  } digit_beat_t;

  logic clk = 1'b0;
  logic rst_ni;

  b2da_in_if  in_bus ();
  b2da_out_if out_bus ();

  binary_to_decimal_ascii #(
    .ValueBits(ValueBits)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Values waiting to be offered, and the digit beats the block still owes.
  logic [ValueW-1:0] pending_values[$];
  digit_beat_t       expected_digits[$];

  int unsigned cycle_count = 0;
  int unsigned values_taken = 0;
  int unsigned total_values = 0;
  int unsigned error_count = 0;
  logic        in_taken = 1'b0;
  logic        hold_off = 1'b0;
  logic [ValueW-1:0] pow10[MaxDigits];

  always #5 clk = ~clk;

  // Every input starts at a known value; reset is released on a falling edge.
  initial begin
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.value = '0;
    out_bus.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_ni <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Splits a value into decimal digits and queues one expected beat per digit, most
  // significant first. A zero value still yields a single '0' digit.
  task automatic predict_decimal_digits(input logic [ValueW-1:0] raw);
    logic [3:0]        rev[MaxDigits];
    logic [ValueW-1:0] rest;
    int                count;
    digit_beat_t       beat;
    rest = raw & ValueMask;
    count = 0;
    do begin
      rev[count] = 4'(rest % Radix);
      rest = rest / Radix;
      count++;
    end while (rest != '0 && count < MaxDigits);
    for (int k = 0; k < count; k++) begin
      beat.ascii_code = AsciiZero + CharW'(rev[count - 1 - k]);
      beat.position = PosW'(k);
      beat.last = (k == count - 1);
      expected_digits.push_back(beat);
    end
  endtask

  // About nine percent of cycles are idle, except inside the quiet window.
  function automatic logic idle_now();
    if (cycle_count >= QuietFrom && cycle_count < QuietTo) begin
      return 1'b0;
    end
    return $urandom_range(99) < 9;
  endfunction

  // Picks a random value from one of several shapes: full 64-bit noise, small numbers,
  // values of every bit length, and neighbors of powers of ten where the digit count
  // changes.
  function automatic logic [ValueW-1:0] random_value();
    logic [ValueW-1:0] v;
    int unsigned       k;
    case ($urandom_range(3))
      0: v = {$urandom, $urandom};
      1: v = ValueW'($urandom_range(1000));
      2: v = {$urandom, $urandom} >> $urandom_range(63);
      default: begin
        k = $urandom_range(MaxDigits - 1);
        v = pow10[k] + ValueW'($urandom_range(2)) - ValueW'(1);
      end
    endcase
    return v;
  endfunction

  // Stimulus: a short directed list first, then random values.
  initial begin
    pow10[0] = 64'd1;
    for (int k = 1; k < MaxDigits; k++) begin
      pow10[k] = pow10[k - 1] * Radix;
    end

    // Zero, single digits, the first carry into two and three digits, the borders of
    // 32 and 64 bits, the largest 19- and smallest 20-digit values, and alternating bits.
    pending_values.push_back(64'd0);
    pending_values.push_back(64'd1);
    pending_values.push_back(64'd9);
    pending_values.push_back(64'd10);
    pending_values.push_back(64'd11);
    pending_values.push_back(64'd99);
    pending_values.push_back(64'd100);
    pending_values.push_back(64'd255);
    pending_values.push_back(64'd1000000);
    pending_values.push_back(64'hFFFF_FFFF);
    pending_values.push_back(64'h1_0000_0000);
    pending_values.push_back(pow10[18] - 64'd1);
    pending_values.push_back(pow10[18]);
    pending_values.push_back(pow10[19] - 64'd1);
    pending_values.push_back(pow10[19]);
    pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_values.push_back(64'h8000_0000_0000_0000);
    pending_values.push_back(64'h5555_5555_5555_5555);
    pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_values.push_back(MaxValue);
    pending_values.push_back(64'd0);
    for (int i = 0; i < RandomItems; i++) begin
      pending_values.push_back(random_value());
    end
    total_values = pending_values.size();

    while (values_taken < total_values) @(posedge clk);
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Once a good share of the values has gone in, the receiver stops taking digits for a
  // long stretch while the sender keeps offering, so the queue fills and in_i stalls.
  initial begin
    while (values_taken < HoldOffAfter) @(negedge clk);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(negedge clk);
    hold_off <= 1'b0;
  end

  // Driver: a value stays on in_i until its beat is taken; a new one is offered on the
  // falling edge after acceptance, or the line idles for a cycle.
  always @(negedge clk) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (pending_values.size() != 0 && !idle_now()) begin
        in_bus.valid <= 1'b1;
        in_bus.value <= pending_values.pop_front();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver side: ready drops at random, and for the whole hold-off stretch.
  always @(negedge clk) begin
    if (!rst_ni || hold_off) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= !idle_now();
    end
  end

  // Monitor: both handshakes are sampled on the rising edge. An accepted value queues
  // its digits; an accepted digit beat is checked against the oldest expected one.
  always @(posedge clk) begin : monitor
    digit_beat_t want;
    in_taken <= rst_ni && in_bus.valid && in_bus.ready;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      predict_decimal_digits(in_bus.value);
      values_taken <= values_taken + 1;
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_digits.size() == 0) begin
        report_mismatch($sformatf("digit beat with nothing expected (code %0d, pos %0d)",
                                  out_bus.digit_char, out_bus.digit_position));
      end else begin
        want = expected_digits.pop_front();
        if (out_bus.digit_char !== want.ascii_code) begin
          report_mismatch($sformatf("digit_char %0d, expected %0d",
                                    out_bus.digit_char, want.ascii_code));
        end
        if (out_bus.digit_position !== want.position) begin
          report_mismatch($sformatf("digit_position %0d, expected %0d",
                                    out_bus.digit_position, want.position));
        end
        if (out_bus.last_digit !== want.last) begin
          report_mismatch($sformatf("last_digit %0b, expected %0b",
                                    out_bus.last_digit, want.last));
        end
      end
    end
  end

  // Watchdog: a run that hangs or crawls is cut off and fails.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
